/* design/swm_pkg.sv */
// Shared types and constants for the sliding-window median filter.
// Used by swm_cell, swm_out_fifo and sliding_window_median; depends on nothing.

package swm_pkg;

   localparam int WINDOW_MAX  = 64;
   localparam int SAMPLE_BITS = 32;
   localparam int SLOT_W      = $clog2(WINDOW_MAX);
   localparam int SIZE_W      = 7;
   localparam int FIFO_DEPTH  = 4;
   localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

   localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(3);

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic [SLOT_W-1:0]             slot_type;

   // Update broadcast to every cell for one accepted word.
   typedef struct packed {
      logic       wr;
      logic       full;
      slot_type   old_slot;
      slot_type   new_slot;
      sample_type key;
   } ctl_type;

   // What a cell shows its two neighbors.
   typedef struct packed {
      sample_type value;
      slot_type   slot;
      logic       greater;
      logic       removed;
   } link_type;

endpackage

/* design/swm_cell.sv */
// One position of the sorted window: a sample and the ring slot it arrived in.
// Depends on swm_pkg; instantiated in a row by sliding_window_median.

module swm_cell (
   input  logic              clock,
   input  swm_pkg::ctl_type  ctl,
   input  logic              cell_valid,
   input  swm_pkg::link_type prev_link,
   input  swm_pkg::link_type next_link,
   output swm_pkg::link_type link
);

   swm_pkg::sample_type value_ff, value_in;
   swm_pkg::slot_type   slot_ff, slot_in;
   logic                greater, del, removed;
   logic                gr_prev, gr_own;
   swm_pkg::sample_type r_prev_value, r_own_value;
   swm_pkg::slot_type   r_prev_slot, r_own_slot;

   always_comb begin
      greater = !cell_valid || (value_ff > ctl.key);
      del     = ctl.full && cell_valid && (slot_ff == ctl.old_slot);
      removed = prev_link.removed || del;

      // Window after the oldest sample is taken out, seen from this cell.
      r_prev_value = prev_link.removed ? value_ff : prev_link.value;
      r_prev_slot  = prev_link.removed ? slot_ff  : prev_link.slot;
      gr_prev      = prev_link.removed ? greater  : prev_link.greater;
      r_own_value  = removed ? next_link.value   : value_ff;
      r_own_slot   = removed ? next_link.slot    : slot_ff;
      gr_own       = removed ? next_link.greater : greater;

      if (gr_prev) begin
         value_in = r_prev_value;
         slot_in  = r_prev_slot;
      end else if (gr_own) begin
         value_in = ctl.key;
         slot_in  = ctl.new_slot;
      end else begin
         value_in = r_own_value;
         slot_in  = r_own_slot;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.wr) begin
         value_ff <= value_in;
         slot_ff  <= slot_in;
      end
   end

   assign link.value   = value_ff;
   assign link.slot    = slot_ff;
   assign link.greater = greater;
   assign link.removed = removed;

endmodule

/* design/swm_out_fifo.sv */
// Small result queue that decouples the sorted row from the result channel.
// Depends on swm_pkg.

module swm_out_fifo (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               push,
   input  swm_pkg::sample_type                push_data,
   output logic [swm_pkg::FIFO_CNT_W-1:0]     count,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output swm_pkg::sample_type                rsp_median
);

   localparam int FIFO_CNT_W = swm_pkg::FIFO_CNT_W;

   swm_pkg::sample_type                   mem_ff [swm_pkg::FIFO_DEPTH];
   logic [swm_pkg::FIFO_PTR_W-1:0]        rd_ff, rd_in, wr_ff, wr_in;
   logic [swm_pkg::FIFO_CNT_W-1:0]        count_ff, count_in;
   logic                                  pop;

   always_comb begin
      pop      = (count_ff != '0) && !rsp_stall;
      rd_in    = pop  ? rd_ff + 1'b1 : rd_ff;
      wr_in    = push ? wr_ff + 1'b1 : wr_ff;
      count_in = count_ff + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff    <= '0;
         wr_ff    <= '0;
         count_ff <= '0;
      end else begin
         rd_ff    <= rd_in;
         wr_ff    <= wr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

   assign count      = count_ff;
   assign rsp_valid  = (count_ff != '0);
   assign rsp_median = mem_ff[rd_ff];

endmodule

/* design/sliding_window_median.sv */
// Top level of the sliding-window median filter: a row of sorting cells,
// window control and a result queue. Depends on swm_pkg, swm_cell, swm_out_fifo.
//
//   Channel | Ports                              | Moves
//   --------+------------------------------------+-----------------------------
//   req     | req_valid, req_stall, req_sample,  | one sample word in
//           | req_restart                        |
//   rsp     | rsp_valid, rsp_stall, rsp_median   | one median word out
//   csr     | csr_write_enable, csr_write_data   | window size
//
// One word is taken per cycle while req_stall is low; the whole row of cells
// removes the oldest sample and inserts the new one in that cycle. The median
// leaves the row in the cycle after and is registered in the result queue.
// A stalled result side fills the four-entry queue and then stalls req.
// Reset clears the window and sets the size to three; cell contents need none.

module sliding_window_median (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [swm_pkg::SAMPLE_BITS-1:0] req_sample,
   input  logic                                req_restart,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [swm_pkg::SAMPLE_BITS-1:0] rsp_median,
   input  logic                                csr_write_enable,
   input  logic [swm_pkg::SIZE_W-1:0]          csr_write_data
);

   localparam int WIN    = swm_pkg::WINDOW_MAX;
   localparam int SIZE_W = swm_pkg::SIZE_W;
   localparam int CNT_W  = swm_pkg::FIFO_CNT_W;

   logic [SIZE_W-1:0]          size_ff, size_in;
   logic [SIZE_W-1:0]          fill_ff, fill_in;
   swm_pkg::slot_type          oldest_ff, oldest_in;
   logic                       pend_ff, pend_in;

   logic [SIZE_W-1:0]          k_eff, fill_eff;
   swm_pkg::slot_type          mid, p_raw, p;
   logic                       accept, full, emit;
   logic [WIN-1:0]             cell_valid;
   logic [WIN-1:0]             tap;
   swm_pkg::ctl_type           ctl;
   swm_pkg::link_type          links [WIN];
   swm_pkg::link_type          left_edge, right_edge;
   swm_pkg::sample_type        median_sel;
   logic [CNT_W-1:0]           out_count;
   logic [CNT_W:0]             claims;

   always_comb begin
      if (size_ff == '0) begin
         k_eff = SIZE_W'(1);
      end else if (size_ff > SIZE_W'(WIN)) begin
         k_eff = SIZE_W'(WIN);
      end else begin
         k_eff = size_ff;
      end
      mid = swm_pkg::SLOT_W'((k_eff - 1'b1) >> 1);

      fill_eff = req_restart ? '0 : fill_ff;
      p_raw    = req_restart ? '0 : oldest_ff;
      p        = (SIZE_W'(p_raw) >= k_eff) ? '0 : p_raw;
      full     = (fill_eff >= k_eff);
      emit     = full || ((fill_eff + 1'b1) == k_eff);

      claims    = (CNT_W + 1)'(out_count) + (CNT_W + 1)'(pend_ff);
      req_stall = (claims >= (CNT_W + 1)'(swm_pkg::FIFO_DEPTH));
      accept    = req_valid && !req_stall;

      for (int i = 0; i < WIN; i++) begin
         cell_valid[i] = (SIZE_W'(i) < fill_eff);
         tap[i]        = (swm_pkg::SLOT_W'(i) == mid);
      end

      ctl.wr       = accept;
      ctl.full     = full;
      ctl.old_slot = p;
      ctl.new_slot = full ? p : swm_pkg::SLOT_W'(fill_eff);
      ctl.key      = req_sample;

      left_edge  = '{value: '0, slot: '0, greater: 1'b0, removed: 1'b0};
      right_edge = '{value: '0, slot: '0, greater: 1'b1, removed: 1'b0};

      size_in   = size_ff;
      fill_in   = fill_ff;
      oldest_in = oldest_ff;
      pend_in   = accept && emit;
      if (csr_write_enable) begin
         size_in   = csr_write_data;
         fill_in   = '0;
         oldest_in = '0;
      end else if (accept) begin
         if (full) begin
            fill_in   = fill_eff;
            oldest_in = ((SIZE_W'(p) + 1'b1) == k_eff) ? '0 : p + 1'b1;
         end else begin
            fill_in   = fill_eff + 1'b1;
            oldest_in = p_raw;
         end
      end
   end

   always_comb begin
      median_sel = '0;
      for (int i = 0; i < WIN; i++) begin
         median_sel = median_sel | (tap[i] ? links[i].value : '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff   <= swm_pkg::SIZE_RESET;
         fill_ff   <= '0;
         oldest_ff <= '0;
         pend_ff   <= 1'b0;
      end else begin
         size_ff   <= size_in;
         fill_ff   <= fill_in;
         oldest_ff <= oldest_in;
         pend_ff   <= pend_in;
      end
   end

   for (genvar i = 0; i < WIN; i++) begin : g_cell
      if (i == 0 && WIN == 1) begin : g_only
         swm_cell u_cell (
            .clock(clock), .ctl(ctl), .cell_valid(cell_valid[i]),
            .prev_link(left_edge), .next_link(right_edge), .link(links[i])
         );
      end else if (i == 0) begin : g_first
         swm_cell u_cell (
            .clock(clock), .ctl(ctl), .cell_valid(cell_valid[i]),
            .prev_link(left_edge), .next_link(links[i+1]), .link(links[i])
         );
      end else if (i == WIN - 1) begin : g_last
         swm_cell u_cell (
            .clock(clock), .ctl(ctl), .cell_valid(cell_valid[i]),
            .prev_link(links[i-1]), .next_link(right_edge), .link(links[i])
         );
      end else begin : g_mid
         swm_cell u_cell (
            .clock(clock), .ctl(ctl), .cell_valid(cell_valid[i]),
            .prev_link(links[i-1]), .next_link(links[i+1]), .link(links[i])
         );
      end
   end

   swm_out_fifo u_out_fifo (
      .clock(clock),
      .reset(reset),
      .push(pend_ff),
      .push_data(median_sel),
      .count(out_count),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_median(rsp_median)
   );

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= k_eff)
      else $error("window fill count exceeds window size");

   a_oldest_bound: assert property (@(posedge clock) disable iff (reset)
      SIZE_W'(oldest_ff) < k_eff)
      else $error("oldest pointer outside window");

   a_remove_found: assert property (@(posedge clock) disable iff (reset)
      (accept && full) |-> links[WIN-1].removed)
      else $error("oldest sample not found in sorted row");

   a_queue_room: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (out_count < CNT_W'(swm_pkg::FIFO_DEPTH)) || !rsp_stall)
      else $error("result queue overflow");

endmodule
